FILE: hdl/wide_value_handle_table_assert.svh
// Assertion macros used by the handle table RTL
`ifndef WIDE_VALUE_HANDLE_TABLE_ASSERT_SVH
`define WIDE_VALUE_HANDLE_TABLE_ASSERT_SVH

// check a condition in the same cycle as its trigger
`define WVHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the cycle after its trigger
`define WVHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/wvht_pkg.sv
// Package with opcodes, constants and result type of the handle table
`timescale 1ns / 1ps
`default_nettype none
package wvht_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } op_t;

    localparam logic [15:0] HANDLE_FLAG = 16'h4000;

    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [63:0] value;
    } result_t;

endpackage
`default_nettype wire

FILE: hdl/wvht_ram.sv
// Generic RAM with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module wvht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/wvht_out_buf.sv
// Output register that holds one result until the consumer takes it
`timescale 1ns / 1ps
`default_nettype none
module wvht_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wvht_pkg::result_t res,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [15:0]       out_lo,
    output logic      [15:0]       out_hi,
    output logic      [63:0]       out_value
);

    logic              valid_reg;
    wvht_pkg::result_t data_reg;

    assign free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            data_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                valid_reg <= 1'b1;
                data_reg  <= res;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_lo    = data_reg.lo;
    assign out_hi    = data_reg.hi;
    assign out_value = data_reg.value;

endmodule
`default_nettype wire

FILE: hdl/wide_value_handle_table.sv
// Accept to ready: a nonzero put scans the used slots in ST_SCAN and ST_DRAIN, one slot
// compared per cycle, to ST_DONE on a hit, else via ST_MISS (entered at once if no slot is used).
// Get by handle does one RAM read (ST_GETRD, ST_GETDAT); any other item goes straight to ST_DONE.
// Throughput: one item at a time; ST_DONE holds while the output register stays full.
// A finished result sits in the output register while the next item is accepted.
// Reset (rst_n, async low) sets the fill count to one; slots at or above it read as zero.
`timescale 1ns / 1ps
`default_nettype none
module wide_value_handle_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [63:0] value,
    input  wire logic [15:0] in_lo,
    input  wire logic [15:0] in_hi,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [15:0] out_lo,
    output logic      [15:0] out_hi,
    output logic      [63:0] out_value
);

    `include "wide_value_handle_table_assert.svh"

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam logic [NW-1:0] DEPTH_N = NW'(TABLE_DEPTH);
    localparam logic [NW-1:0] ONE_N   = NW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MISS,
        ST_GETRD,
        ST_GETDAT,
        ST_DONE
    } state_t;

    state_t            state_reg,    state_next;
    logic [NW-1:0]     next_reg,     next_next;
    logic [AW-1:0]     rd_addr_reg,  rd_addr_next;
    logic [AW-1:0]     chk_slot_reg, chk_slot_next;
    logic              chk_vld_reg,  chk_vld_next;
    logic [AW-1:0]     get_idx_reg,  get_idx_next;
    logic [63:0]       value_reg,    value_next;
    wvht_pkg::result_t res_reg,      res_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [63:0]       ram_rdata;
    logic              match;
    logic              buf_free;
    logic              push;
    logic              accept;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign match     = (ram_rdata == value_reg);
    assign ram_raddr = (state_reg == ST_GETRD) ? get_idx_reg : rd_addr_reg;
    assign ram_waddr = next_reg[AW-1:0];
    assign ram_we    = (state_reg == ST_MISS) && (next_reg < DEPTH_N);
    assign push      = (state_reg == ST_DONE) && buf_free;

    always_comb
    begin
        state_next    = state_reg;
        next_next     = next_reg;
        rd_addr_next  = rd_addr_reg;
        chk_slot_next = chk_slot_reg;
        chk_vld_next  = 1'b0;
        get_idx_next  = get_idx_reg;
        value_next    = value_reg;
        res_next      = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next   = '0;
                    value_next = value;
                    state_next = ST_DONE;
                    case (wvht_pkg::op_t'(op))
                        wvht_pkg::OP_PUT:
                        begin
                            if (value != 64'd0)
                            begin
                                rd_addr_next = AW'(1);
                                state_next   = (next_reg == ONE_N) ? ST_MISS : ST_SCAN;
                            end
                        end
                        wvht_pkg::OP_GET:
                        begin
                            get_idx_next = in_lo[AW-1:0];
                            if (in_hi == wvht_pkg::HANDLE_FLAG)
                            begin
                                if ((in_lo != 16'd0) && (32'(in_lo) < 32'(next_reg)))
                                begin
                                    state_next = ST_GETRD;
                                end
                            end
                            else
                            begin
                                res_next.value = {32'd0, in_hi, in_lo};
                            end
                        end
                        wvht_pkg::OP_CLEAR:
                        begin
                            next_next = ONE_N;
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg && match)
                begin
                    res_next.lo = 16'(chk_slot_reg);
                    res_next.hi = wvht_pkg::HANDLE_FLAG;
                    state_next  = ST_DONE;
                end
                else
                begin
                    chk_vld_next  = 1'b1;
                    chk_slot_next = rd_addr_reg;
                    if (NW'(rd_addr_reg) == next_reg - ONE_N)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + AW'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (match)
                begin
                    res_next.lo = 16'(chk_slot_reg);
                    res_next.hi = wvht_pkg::HANDLE_FLAG;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                if (next_reg < DEPTH_N)
                begin
                    res_next.lo = 16'(next_reg[AW-1:0]);
                    res_next.hi = wvht_pkg::HANDLE_FLAG;
                    next_next   = next_reg + ONE_N;
                end
                else
                begin
                    res_next.lo = value_reg[15:0];
                    res_next.hi = value_reg[31:16];
                end
                state_next = ST_DONE;
            end
            ST_GETRD:
            begin
                state_next = ST_GETDAT;
            end
            ST_GETDAT:
            begin
                res_next.value = ram_rdata;
                state_next     = ST_DONE;
            end
            ST_DONE:
            begin
                if (buf_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            next_reg     <= ONE_N;
            rd_addr_reg  <= '0;
            chk_slot_reg <= '0;
            chk_vld_reg  <= 1'b0;
            get_idx_reg  <= '0;
            value_reg    <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            next_reg     <= next_next;
            rd_addr_reg  <= rd_addr_next;
            chk_slot_reg <= chk_slot_next;
            chk_vld_reg  <= chk_vld_next;
            get_idx_reg  <= get_idx_next;
            value_reg    <= value_next;
            res_reg      <= res_next;
        end
    end

    wvht_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wvht_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res       (res_reg),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_lo    (out_lo),
        .out_hi    (out_hi),
        .out_value (out_value)
    );

    `WVHT_ASSERT_NOW(a_fill_range, 1'b1, (next_reg >= ONE_N) && (next_reg <= DEPTH_N), "fill count out of range")
    `WVHT_ASSERT_NEXT(a_fill_step, ram_we, next_reg == $past(next_reg) + ONE_N, "store write without fill advance")
    `WVHT_ASSERT_NOW(a_push_room, push, !out_valid || out_ready, "result pushed over a pending transfer")
    `WVHT_ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN, NW'(rd_addr_reg) < next_reg, "scan past used slots")

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the wide value handle table: directed rows, then random traffic
`timescale 1ns / 1ps
module tb;

    localparam int DEPTH = 256;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int SEND_GAP_MAX = 40;
    localparam int POOL_MAX = 64;
    localparam int N_DIRECTED = 25;
    localparam logic [15:0] FLAG = wvht_pkg::HANDLE_FLAG;

    typedef struct {
        wvht_pkg::op_t op;
        logic [63:0]   value;
        logic [15:0]   lo;
        logic [15:0]   hi;
        bit            typed;
        logic [15:0]   e_lo;
        logic [15:0]   e_hi;
        logic [63:0]   e_value;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    wvht_pkg::op_t     op;
    logic [63:0]       value;
    logic [15:0]       in_lo;
    logic [15:0]       in_hi;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [15:0]       out_lo;
    logic [15:0]       out_hi;
    logic [63:0]       out_value;

    logic [63:0]       shadow_store [DEPTH];
    int unsigned       shadow_fill;
    wvht_pkg::result_t pending_results [$];
    logic [63:0]       put_pool [$];

    bit                typed_valid;
    wvht_pkg::result_t typed_result;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                n_errors;
    int                cycle_count;
    int                n_results;
    int                n_put_new, n_put_hit, n_put_full, n_put_zero;
    int                n_get_handle, n_get_raw, n_get_zero, n_clear, n_rsvd;

    stim_row_t         directed_rows [N_DIRECTED];

    wide_value_handle_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .value     (value),
        .in_lo     (in_lo),
        .in_hi     (in_hi),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_lo    (out_lo),
        .out_hi    (out_hi),
        .out_value (out_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void wipe_shadow();
        for (int i = 0; i < DEPTH; i++)
            shadow_store[i] = '0;
        shadow_fill = 1;
    endfunction

    function automatic wvht_pkg::result_t handle_table_apply(wvht_pkg::op_t o, logic [63:0] v,
                                                             logic [15:0] lo, logic [15:0] hi);
        wvht_pkg::result_t r;
        int unsigned       span;
        bit                hit;
        r = '0;
        hit = 1'b0;
        case (o)
            wvht_pkg::OP_PUT:
            begin
                if (v == 64'd0)
                begin
                    n_put_zero++;
                end
                else
                begin
                    span = (shadow_fill < DEPTH) ? shadow_fill : DEPTH;
                    for (int unsigned s = 1; s < span && !hit; s++)
                    begin
                        if (shadow_store[s] == v)
                        begin
                            hit = 1'b1;
                            r.lo = s[15:0];
                            r.hi = FLAG;
                        end
                    end
                    if (hit)
                    begin
                        n_put_hit++;
                    end
                    else if (shadow_fill >= DEPTH)
                    begin
                        r.lo = v[15:0];
                        r.hi = v[31:16];
                        n_put_full++;
                    end
                    else
                    begin
                        shadow_store[shadow_fill] = v;
                        r.lo = shadow_fill[15:0];
                        r.hi = FLAG;
                        shadow_fill++;
                        n_put_new++;
                    end
                end
            end
            wvht_pkg::OP_GET:
            begin
                if (lo == 16'd0 && hi == 16'd0)
                begin
                    n_get_zero++;
                end
                else if (hi == FLAG)
                begin
                    r.value = (lo < DEPTH) ? shadow_store[lo] : 64'd0;
                    n_get_handle++;
                end
                else
                begin
                    r.value = {32'd0, hi, lo};
                    n_get_raw++;
                end
            end
            wvht_pkg::OP_CLEAR:
            begin
                wipe_shadow();
                n_clear++;
            end
            default:
            begin
                n_rsvd++;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        wvht_pkg::result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result, actual lo %h hi %h value %h",
                             $time, out_lo, out_hi, out_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_lo", {48'd0, want.lo}, {48'd0, out_lo});
                    check_field("out_hi", {48'd0, want.hi}, {48'd0, out_hi});
                    check_field("out_value", want.value, out_value);
                end
            end
            if (in_valid && in_ready)
            begin
                want = handle_table_apply(op, value, in_lo, in_hi);
                pending_results.push_back(typed_valid ? typed_result : want);
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(wvht_pkg::op_t o, logic [63:0] v, logic [15:0] lo,
                             logic [15:0] hi, bit typed, wvht_pkg::result_t tres);
        int gap;
        gap = 0;
        while (gap < SEND_GAP_MAX && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        typed_valid = typed;
        typed_result = tres;
        op <= o;
        value <= v;
        in_lo <= lo;
        in_hi <= hi;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
    endtask

    task automatic pick_random_item(bit filling, output wvht_pkg::op_t o,
                                    output logic [63:0] v,
                                    output logic [15:0] lo, output logic [15:0] hi);
        int r;
        int r2;
        r = $urandom_range(99);
        r2 = $urandom_range(99);
        v = {$urandom, $urandom};
        lo = 16'($urandom);
        hi = 16'($urandom);
        if (r < (filling ? 90 : 55))
        begin
            o = wvht_pkg::OP_PUT;
            if (r2 < 3)
                v = 64'd0;
            else if (r2 < 18 && put_pool.size() > 0)
                v = put_pool[$urandom_range(put_pool.size() - 1)];
            else
            begin
                if (r2 < 30)
                    v = {32'd0, $urandom};
                else if (r2 < 40)
                    v = 64'($urandom_range(1000, 1));
                put_pool.push_back(v);
                if (put_pool.size() > POOL_MAX)
                    void'(put_pool.pop_front());
            end
        end
        else if (r < (filling ? 98 : 95))
        begin
            o = wvht_pkg::OP_GET;
            if (r2 < 55)
            begin
                hi = FLAG;
                lo = 16'($urandom_range(shadow_fill));
            end
            else if (r2 < 65)
            begin
                hi = FLAG;
            end
            else if (r2 < 70)
            begin
                lo = 16'd0;
                hi = 16'd0;
            end
        end
        else if (!filling && r < 98)
        begin
            o = wvht_pkg::OP_CLEAR;
        end
        else
        begin
            o = wvht_pkg::OP_RSVD;
        end
    endtask

    initial
    begin
        wvht_pkg::result_t tres;
        wvht_pkg::op_t     ro;
        logic [63:0]       rv;
        logic [15:0]       rlo;
        logic [15:0]       rhi;
        int                count;
        bit                filling;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = wvht_pkg::OP_PUT;
        value = '0;
        in_lo = '0;
        in_hi = '0;
        typed_valid = 1'b0;
        typed_result = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_errors = 0;
        cycle_count = 0;
        wipe_shadow();

        directed_rows = '{
            '{wvht_pkg::OP_GET, 64'h0, 16'h0000, 16'h0000, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0005, FLAG, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_PUT, 64'h0, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0, 1'b1,
              16'h1, FLAG, 64'h0},
            '{wvht_pkg::OP_PUT, 64'h1, 16'h0, 16'h0, 1'b1, 16'h2, FLAG, 64'h0},
            '{wvht_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0, 1'b1,
              16'h1, FLAG, 64'h0},
            '{wvht_pkg::OP_PUT, 64'h8000_0000_0000_0000, 16'h0, 16'h0, 1'b1,
              16'h3, FLAG, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0001, FLAG, 1'b1, 16'h0, 16'h0,
              64'hFFFF_FFFF_FFFF_FFFF},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0003, FLAG, 1'b1, 16'h0, 16'h0,
              64'h8000_0000_0000_0000},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0000, FLAG, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'hFFFF, FLAG, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'h00FF, FLAG, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'hFFFF, 16'hFFFF, 1'b1, 16'h0, 16'h0,
              64'h0000_0000_FFFF_FFFF},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0001, 16'h0000, 1'b1, 16'h0, 16'h0, 64'h1},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0000, 16'h8000, 1'b1, 16'h0, 16'h0,
              64'h8000_0000},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0002, 16'h4001, 1'b1, 16'h0, 16'h0,
              64'h4001_0002},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0002, 16'h3FFF, 1'b1, 16'h0, 16'h0,
              64'h3FFF_0002},
            '{wvht_pkg::OP_RSVD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_PUT, 64'h1, 16'h0, 16'h0, 1'b1, 16'h2, FLAG, 64'h0},
            '{wvht_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
              16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0001, FLAG, 1'b1, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_PUT, 64'h0123_4567_89AB_CDEF, 16'h0, 16'h0, 1'b0,
              16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0, 1'b0,
              16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_GET, 64'h0, 16'h0002, FLAG, 1'b0, 16'h0, 16'h0, 64'h0},
            '{wvht_pkg::OP_PUT, 64'h0123_4567_89AB_CDEF, 16'h0, 16'h0, 1'b0,
              16'h0, 16'h0, 64'h0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            tres.lo = directed_rows[i].e_lo;
            tres.hi = directed_rows[i].e_hi;
            tres.value = directed_rows[i].e_value;
            send_item(directed_rows[i].op, directed_rows[i].value, directed_rows[i].lo,
                      directed_rows[i].hi, directed_rows[i].typed, tres);
        end
        tres = '0;

        for (int ph = 0; ph < 4; ph++)
        begin
            hold_until_drained();
            send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 8 : 0;
            recv_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 8 : 0;
            count = (ph % 2 == 0) ? 420 : 355;
            for (int n = 0; n < count; n++)
            begin
                // fill the table to capacity in the even phases before any clear
                filling = (ph % 2 == 0) && (shadow_fill < DEPTH);
                pick_random_item(filling, ro, rv, rlo, rhi);
                send_item(ro, rv, rlo, rhi, 1'b0, tres);
            end
        end

        hold_until_drained();
        repeat (40) @(posedge clk);

        $display("Covered %0d results: puts stored %0d, matched %0d, full %0d, zero %0d",
                 n_results, n_put_new, n_put_hit, n_put_full, n_put_zero);
        $display("Gets by handle %0d, raw %0d, zero pair %0d; clears %0d; reserved ops %0d",
                 n_get_handle, n_get_raw, n_get_zero, n_clear, n_rsvd);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
